### rtl/core/bpcs_pkg.sv
package bpcs_pkg;

   // Width of the press tick counter; the press time saturates at its maximum.
   localparam int HOLD_TICK_BITS = 12;

   // Field widths.
   localparam int TICK_MS_W = 8;
   localparam int THR_W     = 16;
   localparam int DEB_W     = 8;
   localparam int BLINK_W   = 5;
   localparam int MS_W      = 20;
   localparam int CNT_W     = 16;
   localparam int SUM_W     = 32;
   localparam int AVG_W     = 16;

   // Product of hold ticks and tick period, at least as wide as a press time.
   localparam int MUL_W = (HOLD_TICK_BITS + TICK_MS_W > MS_W) ?
                          (HOLD_TICK_BITS + TICK_MS_W) : MS_W;

   localparam logic [HOLD_TICK_BITS-1:0] HOLD_MAX = '1;
   localparam logic [MS_W-1:0]           MS_MAX   = '1;
   localparam logic [CNT_W-1:0]          CNT_MAX  = '1;
   localparam logic [SUM_W-1:0]          SUM_MAX  = '1;
   localparam logic [AVG_W-1:0]          AVG_MAX  = '1;

   // Stream widths.
   localparam int REQ_W = 8;
   localparam int RSP_W = 128;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_THR_MS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALID_MS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEB_RELOAD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_BLINKS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_BLINKS   = 3'd5;

   localparam logic [TICK_MS_W-1:0] RST_TICK_MS      = 8'd16;
   localparam logic [THR_W-1:0]     RST_LONG_THR_MS  = 16'd500;
   localparam logic [THR_W-1:0]     RST_MAX_VALID_MS = 16'd10000;
   localparam logic [DEB_W-1:0]     RST_DEB_RELOAD   = 8'd2;
   localparam logic [BLINK_W-1:0]   RST_SHORT_BLINKS = 5'd5;
   localparam logic [BLINK_W-1:0]   RST_LONG_BLINKS  = 5'd10;

   // Divider: two quotient bits per step, sixteen quotient bits.
   localparam int DIV_STEPS = AVG_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      AVG_SHORT,
      AVG_LONG,
      AVG_ALL
   } avg_sel_type;

   localparam int AVG_NUM = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load_item;
      logic        tick;
      logic        div_load;
      logic        div_step;
      logic        out_load;
      avg_sel_type div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic report;
      logic div_last;
   } dp_sts_type;

endpackage

### rtl/core/bpcs_ctrl.sv
module bpcs_ctrl
   import bpcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type   state_ff, state_in;
   avg_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= AVG_SHORT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      req_tready    = 1'b0;
      cmd.load_item = 1'b0;
      cmd.tick      = 1'b0;
      cmd.div_load  = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.div_sel   = sel_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_TICK;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            sel_in   = AVG_SHORT;
            state_in = sts.report ? ST_DIV_LOAD : ST_FINISH;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               unique case (sel_ff)
                  AVG_SHORT: begin
                     sel_in   = AVG_LONG;
                     state_in = ST_DIV_LOAD;
                  end
                  AVG_LONG: begin
                     sel_in   = AVG_ALL;
                     state_in = ST_DIV_LOAD;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            // The output register takes the result once its previous one is gone.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/core/bpcs_dp.sv
module bpcs_dp
   import bpcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   output logic [RSP_W-1:0]      rsp_tdata
);

   // Configuration registers.
   logic [TICK_MS_W-1:0] tick_ms_ff, tick_ms_in;
   logic [THR_W-1:0]     long_thr_ff, long_thr_in;
   logic [THR_W-1:0]     max_valid_ff, max_valid_in;
   logic [DEB_W-1:0]     deb_reload_ff, deb_reload_in;
   logic [BLINK_W-1:0]   short_blinks_ff, short_blinks_in;
   logic [BLINK_W-1:0]   long_blinks_ff, long_blinks_in;

   // Button and statistics state.
   logic                      last_level_ff, last_level_in;
   logic [DEB_W-1:0]          deb_left_ff, deb_left_in;
   logic                      held_ff, held_in;
   logic [HOLD_TICK_BITS-1:0] held_ticks_ff, held_ticks_in;
   logic                      pending_ff, pending_in;
   logic [MS_W-1:0]           pending_ms_ff, pending_ms_in;
   logic                      green_ff, green_in;
   logic                      red_ff, red_in;
   logic                      yellow_ff, yellow_in;
   logic [BLINK_W-1:0]        blinks_done_ff, blinks_done_in;
   logic [BLINK_W-1:0]        blinks_wanted_ff, blinks_wanted_in;
   logic [CNT_W-1:0]          cnt_total_ff, cnt_total_in;
   logic [CNT_W-1:0]          cnt_short_ff, cnt_short_in;
   logic [CNT_W-1:0]          cnt_long_ff, cnt_long_in;
   logic [SUM_W-1:0]          sum_short_ff, sum_short_in;
   logic [SUM_W-1:0]          sum_long_ff, sum_long_in;

   // Captured item, release and report snapshot.
   logic             level_ff, level_in;
   logic             blink_ff, blink_in;
   logic             report_ff, report_in;
   logic             rel_ff, rel_in;
   logic [MS_W-1:0]  rel_ms_ff, rel_ms_in;
   logic [CNT_W-1:0] snap_total_ff, snap_total_in;
   logic [CNT_W-1:0] snap_short_ff, snap_short_in;
   logic [CNT_W-1:0] snap_long_ff, snap_long_in;
   logic [SUM_W-1:0] snap_sum_s_ff, snap_sum_s_in;
   logic [SUM_W-1:0] snap_sum_l_ff, snap_sum_l_in;

   // Shared divider.
   logic [AVG_W-1:0]     rem_ff, rem_in;
   logic [AVG_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 special_ff, special_in;
   logic [AVG_W-1:0]     avg_ff [AVG_NUM];
   logic [AVG_W-1:0]     avg_in [AVG_NUM];
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   logic [MUL_W-1:0]   prod;
   logic [MS_W-1:0]    ms_sat;
   logic [SUM_W:0]     add_short, add_long;
   logic [SUM_W:0]     load_dvd;
   logic [CNT_W-1:0]   load_dvs;
   logic               load_special;
   logic [CNT_W:0]     t1, t2;
   logic [AVG_W-1:0]   r1, r2;
   logic               b1, b2;

   // Press time in milliseconds, saturated.
   assign prod   = MUL_W'(held_ticks_ff) * MUL_W'(tick_ms_ff);
   assign ms_sat = (prod > MUL_W'(MS_MAX)) ? MS_MAX : prod[MS_W-1:0];

   assign add_short = {1'b0, sum_short_ff} + (SUM_W + 1)'(pending_ms_in);
   assign add_long  = {1'b0, sum_long_ff} + (SUM_W + 1)'(pending_ms_in);

   // Operand selection for one average.
   always_comb begin
      unique case (cmd.div_sel)
         AVG_SHORT: begin
            load_dvd = {1'b0, snap_sum_s_ff};
            load_dvs = snap_short_ff;
         end
         AVG_LONG: begin
            load_dvd = {1'b0, snap_sum_l_ff};
            load_dvs = snap_long_ff;
         end
         default: begin
            load_dvd = {1'b0, snap_sum_s_ff} + {1'b0, snap_sum_l_ff};
            load_dvs = snap_total_ff;
         end
      endcase
   end

   // A zero count gives zero; a quotient beyond sixteen bits gives the maximum.
   assign load_special = (load_dvs == '0) ||
                         (load_dvd[SUM_W:AVG_W] >= {1'b0, load_dvs});

   // Two restoring steps per cycle.
   assign t1 = {rem_ff, quo_ff[AVG_W-1]};
   assign b1 = (t1 >= {1'b0, dvs_ff});
   assign r1 = b1 ? AVG_W'(t1 - {1'b0, dvs_ff}) : t1[AVG_W-1:0];
   assign t2 = {r1, quo_ff[AVG_W-2]};
   assign b2 = (t2 >= {1'b0, dvs_ff});
   assign r2 = b2 ? AVG_W'(t2 - {1'b0, dvs_ff}) : t2[AVG_W-1:0];

   always_comb begin
      tick_ms_in      = tick_ms_ff;
      long_thr_in     = long_thr_ff;
      max_valid_in    = max_valid_ff;
      deb_reload_in   = deb_reload_ff;
      short_blinks_in = short_blinks_ff;
      long_blinks_in  = long_blinks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICK_MS:      tick_ms_in      = csr_data[TICK_MS_W-1:0];
            CSR_LONG_THR_MS:  long_thr_in     = csr_data[THR_W-1:0];
            CSR_MAX_VALID_MS: max_valid_in    = csr_data[THR_W-1:0];
            CSR_DEB_RELOAD:   deb_reload_in   = csr_data[DEB_W-1:0];
            CSR_SHORT_BLINKS: short_blinks_in = csr_data[BLINK_W-1:0];
            CSR_LONG_BLINKS:  long_blinks_in  = csr_data[BLINK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      last_level_in    = last_level_ff;
      deb_left_in      = deb_left_ff;
      held_in          = held_ff;
      held_ticks_in    = held_ticks_ff;
      pending_in       = pending_ff;
      pending_ms_in    = pending_ms_ff;
      green_in         = green_ff;
      red_in           = red_ff;
      yellow_in        = yellow_ff;
      blinks_done_in   = blinks_done_ff;
      blinks_wanted_in = blinks_wanted_ff;
      cnt_total_in     = cnt_total_ff;
      cnt_short_in     = cnt_short_ff;
      cnt_long_in      = cnt_long_ff;
      sum_short_in     = sum_short_ff;
      sum_long_in      = sum_long_ff;
      level_in         = level_ff;
      blink_in         = blink_ff;
      report_in        = report_ff;
      rel_in           = rel_ff;
      rel_ms_in        = rel_ms_ff;
      snap_total_in    = snap_total_ff;
      snap_short_in    = snap_short_ff;
      snap_long_in     = snap_long_ff;
      snap_sum_s_in    = snap_sum_s_ff;
      snap_sum_l_in    = snap_sum_l_ff;

      if (cmd.load_item) begin
         level_in  = req_tdata[0];
         blink_in  = req_tdata[1];
         report_in = req_tdata[2];
      end

      if (cmd.tick) begin
         rel_in    = 1'b0;
         rel_ms_in = '0;

         // Debounce: reload on a change, count down while the level holds.
         if (level_ff == last_level_ff) begin
            if (deb_left_ff != '0) begin
               deb_left_in = deb_left_ff - 1'b1;
            end
         end else begin
            last_level_in = level_ff;
            deb_left_in   = deb_reload_ff;
         end

         if (deb_left_in == '0) begin
            if (level_ff) begin
               if (!held_ff) begin
                  held_in       = 1'b1;
                  held_ticks_in = '0;
                  green_in      = 1'b0;
                  red_in        = 1'b0;
               end else if (held_ticks_ff != HOLD_MAX) begin
                  held_ticks_in = held_ticks_ff + 1'b1;
               end
            end else if (held_ff) begin
               held_in       = 1'b0;
               pending_ms_in = ms_sat;
               green_in      = (ms_sat < MS_W'(long_thr_ff));
               red_in        = !(ms_sat < MS_W'(long_thr_ff));
               pending_in    = 1'b1;
               rel_in        = 1'b1;
               rel_ms_in     = ms_sat;
            end
         end

         // Statistics and blinking; a press posted this tick is seen here.
         if (blink_ff) begin
            if (pending_in) begin
               pending_in = 1'b0;
               if ((pending_ms_in != '0) && (pending_ms_in < MS_W'(max_valid_ff))) begin
                  if (cnt_total_ff != CNT_MAX) begin
                     cnt_total_in = cnt_total_ff + 1'b1;
                  end
                  if (pending_ms_in < MS_W'(long_thr_ff)) begin
                     if (cnt_short_ff != CNT_MAX) begin
                        cnt_short_in = cnt_short_ff + 1'b1;
                     end
                     sum_short_in     = add_short[SUM_W] ? SUM_MAX : add_short[SUM_W-1:0];
                     blinks_wanted_in = short_blinks_ff;
                  end else begin
                     if (cnt_long_ff != CNT_MAX) begin
                        cnt_long_in = cnt_long_ff + 1'b1;
                     end
                     sum_long_in      = add_long[SUM_W] ? SUM_MAX : add_long[SUM_W-1:0];
                     blinks_wanted_in = long_blinks_ff;
                  end
                  blinks_done_in = '0;
               end
            end
            if (blinks_done_in < blinks_wanted_in) begin
               if (yellow_ff) begin
                  yellow_in      = 1'b0;
                  blinks_done_in = blinks_done_in + 1'b1;
               end else begin
                  yellow_in = 1'b1;
               end
            end else if (blinks_wanted_in != '0) begin
               yellow_in        = 1'b0;
               blinks_wanted_in = '0;
            end
         end

         // Report: take a snapshot for the divider and clear the statistics.
         if (report_ff) begin
            snap_total_in = cnt_total_in;
            snap_short_in = cnt_short_in;
            snap_long_in  = cnt_long_in;
            snap_sum_s_in = sum_short_in;
            snap_sum_l_in = sum_long_in;
            cnt_total_in  = '0;
            cnt_short_in  = '0;
            cnt_long_in   = '0;
            sum_short_in  = '0;
            sum_long_in   = '0;
         end
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      step_in    = step_ff;
      special_in = special_ff;
      for (int i = 0; i < AVG_NUM; i++) begin
         avg_in[i] = avg_ff[i];
      end

      if (cmd.div_load) begin
         rem_in     = load_dvd[SUM_W-1:AVG_W];
         quo_in     = load_dvd[AVG_W-1:0];
         dvs_in     = load_dvs;
         step_in    = '0;
         special_in = load_special;
         if (load_special) begin
            avg_in[cmd.div_sel] = (load_dvs == '0) ? '0 : AVG_MAX;
         end
      end else if (cmd.div_step) begin
         rem_in  = r2;
         quo_in  = {quo_ff[AVG_W-3:0], b1, b2};
         step_in = step_ff + 1'b1;
         if (sts.div_last && !special_ff) begin
            avg_in[cmd.div_sel] = {quo_ff[AVG_W-3:0], b1, b2};
         end
      end
   end

   assign sts.div_last = (step_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign sts.report   = report_ff;

   always_comb begin
      rsp_tdata_in = rsp_tdata_ff;
      if (cmd.out_load) begin
         if (report_ff) begin
            rsp_tdata_in = {7'b0, avg_ff[AVG_ALL], avg_ff[AVG_LONG], avg_ff[AVG_SHORT],
                            snap_long_ff, snap_short_ff, snap_total_ff, 1'b1,
                            rel_ms_ff, rel_ff, yellow_ff, red_ff, green_ff};
         end else begin
            rsp_tdata_in = {7'b0, 96'b0, 1'b0,
                            rel_ms_ff, rel_ff, yellow_ff, red_ff, green_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff       <= RST_TICK_MS;
         long_thr_ff      <= RST_LONG_THR_MS;
         max_valid_ff     <= RST_MAX_VALID_MS;
         deb_reload_ff    <= RST_DEB_RELOAD;
         short_blinks_ff  <= RST_SHORT_BLINKS;
         long_blinks_ff   <= RST_LONG_BLINKS;
         last_level_ff    <= 1'b0;
         deb_left_ff      <= '0;
         held_ff          <= 1'b0;
         held_ticks_ff    <= '0;
         pending_ff       <= 1'b0;
         pending_ms_ff    <= '0;
         green_ff         <= 1'b0;
         red_ff           <= 1'b0;
         yellow_ff        <= 1'b0;
         blinks_done_ff   <= '0;
         blinks_wanted_ff <= '0;
         cnt_total_ff     <= '0;
         cnt_short_ff     <= '0;
         cnt_long_ff      <= '0;
         sum_short_ff     <= '0;
         sum_long_ff      <= '0;
      end else begin
         tick_ms_ff       <= tick_ms_in;
         long_thr_ff      <= long_thr_in;
         max_valid_ff     <= max_valid_in;
         deb_reload_ff    <= deb_reload_in;
         short_blinks_ff  <= short_blinks_in;
         long_blinks_ff   <= long_blinks_in;
         last_level_ff    <= last_level_in;
         deb_left_ff      <= deb_left_in;
         held_ff          <= held_in;
         held_ticks_ff    <= held_ticks_in;
         pending_ff       <= pending_in;
         pending_ms_ff    <= pending_ms_in;
         green_ff         <= green_in;
         red_ff           <= red_in;
         yellow_ff        <= yellow_in;
         blinks_done_ff   <= blinks_done_in;
         blinks_wanted_ff <= blinks_wanted_in;
         cnt_total_ff     <= cnt_total_in;
         cnt_short_ff     <= cnt_short_in;
         cnt_long_ff      <= cnt_long_in;
         sum_short_ff     <= sum_short_in;
         sum_long_ff      <= sum_long_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      blink_ff      <= blink_in;
      report_ff     <= report_in;
      rel_ff        <= rel_in;
      rel_ms_ff     <= rel_ms_in;
      snap_total_ff <= snap_total_in;
      snap_short_ff <= snap_short_in;
      snap_long_ff  <= snap_long_in;
      snap_sum_s_ff <= snap_sum_s_in;
      snap_sum_l_ff <= snap_sum_l_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      step_ff       <= step_in;
      special_ff    <= special_in;
      for (int i = 0; i < AVG_NUM; i++) begin
         avg_ff[i] <= avg_in[i];
      end
      rsp_tdata_ff  <= rsp_tdata_in;
   end

   assign rsp_tdata = rsp_tdata_ff;

endmodule

### rtl/core/button_press_classifier_stats_top.sv
// Button press classifier with statistics. Each request transfer is one base tick
// carrying the raw button level, a blink strobe and a report strobe, and it yields
// exactly one response transfer with the LED states, the release of a press with its
// duration in milliseconds, and, on a report, the counts and averages since the last
// report. The level is debounced by a counter that reloads on every change; a press
// shorter than long_threshold_ms lights green, any other red, and the next blink
// step counts a valid one and starts a burst of yellow blinks. A tick without a
// report takes the request, updates the state and loads the response register,
// each in its own state. A tick with a report also runs the shared divider between
// the state update and the response load; it forms the three averages one after
// another, each by a load step and then steps of two quotient bits. The response
// sits in an output register, so a new request is taken while the previous
// response still waits; the next response is only loaded once that one has left,
// and until then no further request is taken.
// Configuration writes are accepted in every cycle and belong in idle periods only.
module button_press_classifier_stats_top
   import bpcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bit 0 button_level, bit 1 blink_step, bit 2 report_now, bits 7:3 zero.
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0 up: green_led, red_led, yellow_led, press_released, press_ms (20),
   // report_valid, total_count (16), short_count (16), long_count (16),
   // avg_short_ms (16), avg_long_ms (16), avg_all_ms (16), then zero fill.
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Register writes never stall.
   assign csr_ready = 1'b1;

   // The controller sequences each tick, the divider passes and the response.
   bpcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the configuration, the button and statistics state,
   // the divider and the response register.
   bpcs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### bench/tb_button_press_classifier_stats_top.sv
`timescale 1ns / 1ps

import bpcs_pkg::*;

// One response transfer, unpacked from rsp_tdata; the first member sits in the highest bits.
typedef struct packed {
   logic [AVG_W-1:0] avg_all;
   logic [AVG_W-1:0] avg_long;
   logic [AVG_W-1:0] avg_short;
   logic [CNT_W-1:0] long_cnt;
   logic [CNT_W-1:0] short_cnt;
   logic [CNT_W-1:0] total_cnt;
   logic             report_valid;
   logic [MS_W-1:0]  press_ms;
   logic             released;
   logic             yellow;
   logic             red;
   logic             green;
} tick_result_type;

// Settings and stimulus shape of one test phase.
typedef struct {
   int tick;
   int thr;
   int mv;
   int deb;
   int sb;
   int lb;
   int budget;
   int blink_pct;
   int report_pct;
   int gap_max;
} phase_type;

class press_stats_board;
   // Register copies.
   bit [TICK_MS_W-1:0]      tick_ms;
   bit [THR_W-1:0]          long_thr;
   bit [THR_W-1:0]          max_valid;
   bit [DEB_W-1:0]          deb_reload;
   bit [BLINK_W-1:0]        short_blinks;
   bit [BLINK_W-1:0]        long_blinks;
   // Classifier state.
   bit                      last_lvl;
   bit [DEB_W-1:0]          deb_left;
   bit                      held;
   bit [HOLD_TICK_BITS-1:0] hold_ticks;
   bit                      pending;
   bit [MS_W-1:0]           pend_ms;
   bit                      green, red, yellow;
   bit [BLINK_W-1:0]        blinks_done, blinks_wanted;
   bit [CNT_W-1:0]          n_total, n_short, n_long;
   bit [SUM_W-1:0]          sum_short, sum_long;

   tick_result_type         expected_ticks[$];
   int                      errors;
   int                      checked;

   function new();
      tick_ms       = RST_TICK_MS;
      long_thr      = RST_LONG_THR_MS;
      max_valid     = RST_MAX_VALID_MS;
      deb_reload    = RST_DEB_RELOAD;
      short_blinks  = RST_SHORT_BLINKS;
      long_blinks   = RST_LONG_BLINKS;
      last_lvl      = 0;
      deb_left      = 0;
      held          = 0;
      hold_ticks    = 0;
      pending       = 0;
      pend_ms       = 0;
      green         = 0;
      red           = 0;
      yellow        = 0;
      blinks_done   = 0;
      blinks_wanted = 0;
      n_total       = 0;
      n_short       = 0;
      n_long        = 0;
      sum_short     = 0;
      sum_long      = 0;
      errors        = 0;
      checked       = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_TICK_MS:      tick_ms      = val[TICK_MS_W-1:0];
         CSR_LONG_THR_MS:  long_thr     = val[THR_W-1:0];
         CSR_MAX_VALID_MS: max_valid    = val[THR_W-1:0];
         CSR_DEB_RELOAD:   deb_reload   = val[DEB_W-1:0];
         CSR_SHORT_BLINKS: short_blinks = val[BLINK_W-1:0];
         CSR_LONG_BLINKS:  long_blinks  = val[BLINK_W-1:0];
         default: ;
      endcase
   endfunction

   function bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

   function bit [SUM_W-1:0] sat_add(bit [SUM_W-1:0] a, bit [MS_W-1:0] b);
      longint unsigned s;
      s = a;
      s += b;
      return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function bit [AVG_W-1:0] mean16(longint unsigned sum, bit [CNT_W-1:0] cnt);
      longint unsigned q;
      if (cnt == 0) return '0;
      q = sum / cnt;
      return (q > AVG_MAX) ? AVG_MAX : q[AVG_W-1:0];
   endfunction

   function void note_tick(bit lvl, bit blk, bit rpt);
      tick_result_type r;
      longint unsigned ms;
      longint unsigned both;
      r = '0;
      if (lvl == last_lvl) begin
         if (deb_left != 0) deb_left--;
      end else begin
         last_lvl = lvl;
         deb_left = deb_reload;
      end
      if (deb_left == 0) begin
         if (lvl) begin
            if (!held) begin
               held       = 1;
               hold_ticks = 0;
               green      = 0;
               red        = 0;
            end else if (hold_ticks != HOLD_MAX) begin
               hold_ticks++;
            end
         end else if (held) begin
            ms = hold_ticks;
            ms = ms * tick_ms;
            held    = 0;
            pend_ms = (ms > MS_MAX) ? MS_MAX : ms[MS_W-1:0];
            green   = (pend_ms < long_thr);
            red     = !(pend_ms < long_thr);
            pending = 1;
            r.released = 1;
            r.press_ms = pend_ms;
         end
      end
      if (blk) begin
         if (pending) begin
            pending = 0;
            if (pend_ms != 0 && pend_ms < max_valid) begin
               n_total = sat_inc(n_total);
               if (pend_ms < long_thr) begin
                  n_short       = sat_inc(n_short);
                  sum_short     = sat_add(sum_short, pend_ms);
                  blinks_wanted = short_blinks;
               end else begin
                  n_long        = sat_inc(n_long);
                  sum_long      = sat_add(sum_long, pend_ms);
                  blinks_wanted = long_blinks;
               end
               blinks_done = 0;
            end
         end
         if (blinks_done < blinks_wanted) begin
            if (yellow) begin
               yellow = 0;
               blinks_done++;
            end else begin
               yellow = 1;
            end
         end else if (blinks_wanted != 0) begin
            yellow        = 0;
            blinks_wanted = 0;
         end
      end
      if (rpt) begin
         both = sum_short;
         both += sum_long;
         r.report_valid = 1;
         r.total_cnt    = n_total;
         r.short_cnt    = n_short;
         r.long_cnt     = n_long;
         r.avg_short    = mean16(sum_short, n_short);
         r.avg_long     = mean16(sum_long, n_long);
         r.avg_all      = mean16(both, n_total);
         n_total   = 0;
         n_short   = 0;
         n_long    = 0;
         sum_short = 0;
         sum_long  = 0;
      end
      r.green  = green;
      r.red    = red;
      r.yellow = yellow;
      expected_ticks.push_back(r);
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task compare_field(string name, longint unsigned g, longint unsigned w);
      if (g != w)
         report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                   checked, name, g, w));
   endtask

   task check_tick_result(logic [RSP_W-1:0] data);
      tick_result_type got;
      tick_result_type want;
      if (expected_ticks.size() == 0) begin
         report_mismatch("response transfer with no tick outstanding");
         return;
      end
      got  = data[$bits(tick_result_type)-1:0];
      want = expected_ticks.pop_front();
      compare_field("green_led", got.green, want.green);
      compare_field("red_led", got.red, want.red);
      compare_field("yellow_led", got.yellow, want.yellow);
      compare_field("press_released", got.released, want.released);
      compare_field("press_ms", got.press_ms, want.press_ms);
      compare_field("report_valid", got.report_valid, want.report_valid);
      compare_field("total_count", got.total_cnt, want.total_cnt);
      compare_field("short_count", got.short_cnt, want.short_cnt);
      compare_field("long_count", got.long_cnt, want.long_cnt);
      compare_field("avg_short_ms", got.avg_short, want.avg_short);
      compare_field("avg_long_ms", got.avg_long, want.avg_long);
      compare_field("avg_all_ms", got.avg_all, want.avg_all);
      checked++;
   endtask
endclass

module tb_button_press_classifier_stats_top;

   // Safety net only; a run that reaches this limit ends with an error.
   localparam int CYCLE_LIMIT  = 2_000_000;
   // Covers any work still in flight in the block after the last expected response transfer.
   localparam int DRAIN_CYCLES = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   press_stats_board board;

   int cycle_count   = 0;
   int stall_pct     = 0;
   int stall_timer   = 0;
   int burst_left    = 0;
   int gap_max       = 0;
   int sent_in_phase = 0;
   bit stream_idle   = 1;

   button_press_classifier_stats_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver stalls with a probability that is redrawn whenever a random timer runs
   // out, so some stretches take every response and others back up hard.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_timer == 0) begin
            stall_pct   <= $urandom_range(0, 3) * 25;
            stall_timer <= $urandom_range(20, 200);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Every response transfer is checked against the oldest predicted tick.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_tick_result(rsp_tdata);
   end

   function automatic bit coin(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Offers one tick and waits for its transfer. Valid stays high into the next tick of
   // a burst; at the end of a burst the stream goes quiet for a random gap if gap_max > 0.
   task automatic send_tick(input bit lvl, input bit blk, input bit rpt);
      req_tvalid  <= 1'b1;
      req_tdata   <= {{(REQ_W - 3){1'b0}}, rpt, blk, lvl};
      stream_idle  = 0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_tick(lvl, blk, rpt);
      sent_in_phase++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (gap_max > 0) begin
            req_tvalid  <= 1'b0;
            stream_idle  = 1;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   // Stops the stream and waits until every predicted response has been taken, then
   // lets the block run dry before anything touches its registers.
   task automatic settle();
      if (!stream_idle) begin
         req_tvalid  <= 1'b0;
         stream_idle  = 1;
      end
      while (board.expected_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all six registers back to back; valid is only lowered after the last one.
   task automatic apply_config(input phase_type p);
      logic [CSR_IDX_W-1:0]  idx[6];
      logic [CSR_DATA_W-1:0] val[6];
      int                    k;
      idx[0] = CSR_TICK_MS;      val[0] = p.tick;
      idx[1] = CSR_LONG_THR_MS;  val[1] = p.thr;
      idx[2] = CSR_MAX_VALID_MS; val[2] = p.mv;
      idx[3] = CSR_DEB_RELOAD;   val[3] = p.deb;
      idx[4] = CSR_SHORT_BLINKS; val[4] = p.sb;
      idx[5] = CSR_LONG_BLINKS;  val[5] = p.lb;
      for (k = 0; k < 6; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.write_reg(idx[k], val[k]);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly well formed presses: optional contact bounce, a hold long enough to pass the
   // debounce plus a random duration, then a release held past the debounce too. The hold
   // is sized from the current threshold so that short and long presses both show up, and
   // now and then it is drawn up to just past the validity limit, within a cap that keeps
   // the run short. One press in ten is replaced by noise.
   task automatic run_phase(input phase_type p);
      int thr_ticks;
      int mv_ticks;
      int hold;
      int n;
      int k;
      gap_max       = p.gap_max;
      sent_in_phase = 0;
      thr_ticks     = board.long_thr / board.tick_ms;
      mv_ticks      = board.max_valid / board.tick_ms;
      while (sent_in_phase < p.budget) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
               send_tick($urandom_range(0, 1), coin(p.blink_pct), coin(p.report_pct));
         end else begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
               send_tick(k[0] == 1'b0, coin(p.blink_pct), coin(p.report_pct));
            if ($urandom_range(0, 9) == 0)
               hold = $urandom_range(0, (mv_ticks + 20 > 120) ? 120 : mv_ticks + 20);
            else
               hold = $urandom_range(0, (2 * thr_ticks + 8 > 60) ? 60 : 2 * thr_ticks + 8);
            for (k = 0; k < board.deb_reload + 1 + hold; k++)
               send_tick(1'b1, coin(p.blink_pct), coin(p.report_pct));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
               send_tick(k[0] == 1'b1, coin(p.blink_pct), coin(p.report_pct));
            n = board.deb_reload + 1 + $urandom_range(0, 6);
            for (k = 0; k < n; k++)
               send_tick(1'b0, coin(p.blink_pct), coin(p.report_pct));
         end
      end
   endtask

   initial begin
      phase_type plan[$];
      phase_type p;
      bit [2:0]  opening[25];
      int        i;

      board = new();

      // Directed ticks, each {report_now, blink_step, button_level}: a report with no
      // presses (all averages zero), a press released with zero duration that the blink
      // step then drops as invalid, a short press, a blink step combined with a report,
      // a bounce during the blinking and a run of blink steps.
      opening = '{3'b100, 3'b001, 3'b001, 3'b001, 3'b000, 3'b000, 3'b000, 3'b010,
                  3'b001, 3'b001, 3'b001, 3'b001, 3'b001, 3'b000, 3'b000, 3'b000,
                  3'b110, 3'b001, 3'b010, 3'b010, 3'b010, 3'b010, 3'b010, 3'b010,
                  3'b010};

      // Phases: the reset values, the low extremes of every register, the high extremes
      // of the tick period, the thresholds and the blink counts with a moderate debounce,
      // a zero debounce with only short presses, rare blink steps with a low validity
      // limit so that releases overwrite each other and long presses go invalid, and a
      // few settings drawn at random.
      plan.push_back('{RST_TICK_MS, RST_LONG_THR_MS, RST_MAX_VALID_MS, RST_DEB_RELOAD,
                       RST_SHORT_BLINKS, RST_LONG_BLINKS, 100, 30, 3, 6});
      plan.push_back('{1, 0, 1, 0, 0, 0, 60, 50, 10, 4});
      plan.push_back('{255, 65535, 65535, 16, 31, 31, 80, 40, 4, 3});
      plan.push_back('{1, 65535, 65535, 0, 31, 0, 80, 60, 4, 0});
      plan.push_back('{8, 100, 400, 1, 3, 7, 70, 10, 5, 8});
      for (i = 0; i < 3; i++) begin
         p.tick       = $urandom_range(1, 40);
         p.thr        = $urandom_range(0, 2000);
         p.mv         = $urandom_range(1, 20000);
         p.deb        = $urandom_range(0, 4);
         p.sb         = $urandom_range(0, 31);
         p.lb         = $urandom_range(0, 31);
         p.budget     = 50;
         p.blink_pct  = $urandom_range(5, 70);
         p.report_pct = $urandom_range(1, 8);
         p.gap_max    = $urandom_range(0, 8);
         plan.push_back(p);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      gap_max = 3;
      for (i = 0; i < 25; i++)
         send_tick(opening[i][0], opening[i][1], opening[i][2]);

      foreach (plan[j]) begin
         settle();
         apply_config(plan[j]);
         run_phase(plan[j]);
      end
      settle();

      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
